// File: sv/sli_pkg.sv
// Shared types and constants for the sorted list insert/remove block.
// No dependencies; the cell, the top module and the testbench import this package.
package sli_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 16;
  localparam int SUM_BITS   = 22;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int CMP_BITS   = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;

  // OR-reduction trees over the cell row work on groups of this size
  localparam int GRP_SIZE = 8;
  localparam int NUM_GRPS = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // Port field widths
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int VAL_W    = 16;
  localparam int TOTAL_W  = 22;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_REMOVED    = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_OVER_TOTAL = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_SEL,
    S_FIN
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e              op;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_BITS-1:0]   count;
  } cell_cmd_t;

endpackage

// File: sv/sli_in_if.sv
// Input channel of the sorted list block: valid/ready plus one request.
// No dependencies.
interface sli_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// File: sv/sli_out_if.sv
// Output channel of the sorted list block: valid/ready plus one result.
// No dependencies.
interface sli_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  entry_count;
  logic [15:0] smallest;
  logic [15:0] largest;
  logic [21:0] stored_total;

  modport source (output valid, output status, output entry_count, output smallest,
                  output largest, output stored_total, input ready);
  modport sink   (input valid, input status, input entry_count, input smallest,
                  input largest, input stored_total, output ready);
endinterface

// File: sv/sli_cell.sv
// One storage cell of the sorted row: holds one value, compares it with the
// broadcast item and shifts from a neighbor on insert/remove. Uses sli_pkg.
module sli_cell (
  input  logic                          clk_i,
  input  sli_pkg::cell_cmd_t            cmd_i,
  input  logic [sli_pkg::CNT_BITS-1:0]  idx_i,
  input  logic [sli_pkg::VALUE_BITS-1:0] left_val_i,
  input  logic                          left_gt_i,
  input  logic [sli_pkg::VALUE_BITS-1:0] right_val_i,
  output logic [sli_pkg::VALUE_BITS-1:0] val_o,
  output logic                          gt_o,
  output logic                          eq_o,
  output logic [sli_pkg::VALUE_BITS-1:0] last_val_o
);
  import sli_pkg::*;

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  valid;
  logic                  ge;
  logic                  at_count;
  logic                  is_last;

  assign valid    = idx_i < cmd_i.count;
  assign gt_o     = valid && (val_q > cmd_i.value);
  assign ge       = valid && (val_q >= cmd_i.value);
  assign eq_o     = valid && (val_q == cmd_i.value);
  assign at_count = idx_i == cmd_i.count;
  assign is_last  = CNT_BITS'(idx_i + 1'b1) == cmd_i.count;

  assign val_o      = val_q;
  assign last_val_o = is_last ? val_q : '0;

  // Insert: cells past the slot take the left value, the slot takes the item.
  // Remove: cells from the match onward take the right value.
  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (left_gt_i) begin
          val_d = left_val_i;
        end else if (gt_o || at_count) begin
          val_d = cmd_i.value;
        end
      end
      OP_REMOVE: begin
        if (ge) begin
          val_d = right_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: sv/sorted_list_insert_remove.sv
// Sorted list insert/remove: a row of compare-and-shift cells with a small
// sequencer. Depends on sli_pkg, sli_in_if, sli_out_if and sli_cell.
//
// Usage: in_i carries one request per transfer (action 0 inserts value at
// its sorted place after equal entries, action 1 removes one equal entry).
// out_o returns exactly one result per request: status, entry count,
// smallest and largest entries (0 when empty) and the running total.
// in_i.ready is high only while the sequencer is idle, so one request
// is worked at a time. The steps are compare, commit (all cells shift
// in parallel), pick of the largest entry, and result; the two OR trees
// across the row are each split over a register stage.
// The result register holds the finished result while out_o.ready is low;
// the next request can be taken then, but its result waits in the final
// step until the register frees up.
// Reset (rst_ni low) empties the list and clears the total; cell contents
// are not cleared since only entries below the count are ever used.
module sorted_list_insert_remove (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_in_if.sink    in_i,
  sli_out_if.source out_o
);
  import sli_pkg::*;

  state_e state_q, state_d;

  logic                  act_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [SUM_BITS-1:0]   sum_q, sum_d;

  logic [NUM_GRPS-1:0]   eq_grp_d, eq_grp_q;
  logic [VALUE_BITS-1:0] hi_grp_d [NUM_GRPS];
  logic [VALUE_BITS-1:0] hi_grp_q [NUM_GRPS];
  logic [VALUE_BITS-1:0] largest;

  logic [VALUE_BITS-1:0] cell_val  [CAPACITY];
  logic [VALUE_BITS-1:0] cell_last [CAPACITY];
  logic [CAPACITY-1:0]   cell_gt;
  logic [CAPACITY-1:0]   cell_eq;

  cell_cmd_t cmd;
  status_e   status;
  logic      found;
  logic      over;
  logic      full;
  logic      accept;
  logic      load_out;
  logic      in_ready;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic [VAL_W-1:0]      out_small_q;
  logic [VAL_W-1:0]      out_large_q;
  logic [TOTAL_W-1:0]    out_total_q;

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_val;
    logic                  left_gt;
    logic [VALUE_BITS-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    sli_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .idx_i       (CNT_BITS'(i)),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i]),
      .eq_o        (cell_eq[i]),
      .last_val_o  (cell_last[i])
    );
  end

  // ------------------------------------------------- group OR-reductions
  always_comb begin
    for (int g = 0; g < NUM_GRPS; g++) begin
      eq_grp_d[g] = 1'b0;
      hi_grp_d[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          eq_grp_d[g] = eq_grp_d[g] | cell_eq[g * GRP_SIZE + k];
          hi_grp_d[g] = hi_grp_d[g] | cell_last[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eq_grp_q <= eq_grp_d;
    hi_grp_q <= hi_grp_d;
  end

  always_comb begin
    largest = '0;
    for (int g = 0; g < NUM_GRPS; g++) begin
      largest = largest | hi_grp_q[g];
    end
  end

  // ------------------------------------------------------------- decision
  assign found = |eq_grp_q;
  assign over  = CMP_BITS'(val_q) > CMP_BITS'(sum_q);
  assign full  = count_q == CNT_BITS'(CAPACITY);

  always_comb begin
    if (!act_q) begin
      status = full ? ST_FULL : ST_INSERTED;
    end else if (over) begin
      status = ST_OVER_TOTAL;
    end else begin
      status = found ? ST_REMOVED : ST_NOT_FOUND;
    end
  end

  always_comb begin
    cmd.value = val_q;
    cmd.count = count_q;
    cmd.op    = OP_HOLD;
    count_d   = count_q;
    sum_d     = sum_q;
    if (state_q == S_UPD) begin
      if (status == ST_INSERTED) begin
        cmd.op  = OP_INSERT;
        count_d = count_q + 1'b1;
        sum_d   = sum_q + SUM_BITS'(val_q);
      end else if (status == ST_REMOVED) begin
        cmd.op  = OP_REMOVE;
        count_d = count_q - 1'b1;
        sum_d   = sum_q - SUM_BITS'(val_q);
      end
    end
  end

  // --------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  state_d = S_SEL;
      S_SEL:  state_d = S_FIN;
      S_FIN:  if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready = 1'b1;
      S_FIN:   load_out = !out_valid_q || out_o.ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_i.action;
      val_q <= VALUE_BITS'(in_i.value);
    end
  end

  // status of the committed item, held for the result step
  status_e status_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      status_q <= status;
    end
  end

  // -------------------------------------------------------- result reg
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_count_q  <= COUNT_W'(count_q);
      out_small_q  <= (count_q != '0) ? VAL_W'(cell_val[0]) : '0;
      out_large_q  <= (count_q != '0) ? VAL_W'(largest) : '0;
      out_total_q  <= TOTAL_W'(sum_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.entry_count  = out_count_q;
  assign out_o.smallest     = out_small_q;
  assign out_o.largest      = out_large_q;
  assign out_o.stored_total = out_total_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_count_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_UPD))
    else $error("entry count changed outside commit step");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && status_q == ST_FULL) |-> (count_q == CNT_BITS'(CAPACITY)))
    else $error("full reported while list not full");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_count_q != '0 |-> out_small_q <= out_large_q)
    else $error("smallest above largest");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for sorted_list_insert_remove: random and directed
// insert/remove requests, a per-request list predictor and a result scoreboard.
// Depends on sli_pkg, sli_in_if, sli_out_if and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  localparam logic ACT_INSERT     = 1'b0;
  localparam logic ACT_REMOVE     = 1'b1;
  localparam int   RANDOM_ITEMS   = 450;
  localparam int   IDLE_LIMIT     = 3000;
  localparam int   HOLDOFF_CYCLES = 400;
  localparam int   MAX_REPORTS    = 10;

  typedef struct packed {
    logic              action;
    logic [VAL_W-1:0]  value;
    logic              wait_drain;  // hold this request until nothing is outstanding
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
    logic [VAL_W-1:0]   smallest;
    logic [VAL_W-1:0]   largest;
    logic [TOTAL_W-1:0] stored_total;
  } list_result_t;

  logic clk;
  logic rst_ni;

  sli_in_if  in_if ();
  sli_out_if out_if ();

  sorted_list_insert_remove u_top (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  request_t     pending_reqs[$];
  list_result_t expected_results[$];

  // predictor state
  logic [VAL_W-1:0]   sorted_list[$];
  logic [TOTAL_W-1:0] list_total;

  // stimulus-side view of the store, used only to pick useful values
  logic [VAL_W-1:0] gen_pool[$];
  int unsigned      gen_total;

  int unsigned items_acc;
  int unsigned results_got;
  int unsigned mismatches;
  int unsigned idle_cycles;

  always #5 clk = ~clk;

  function automatic list_result_t list_apply(request_t req);
    list_result_t res;
    int pos;
    if (req.action == ACT_INSERT) begin
      if (sorted_list.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes after any equal ones
        pos = sorted_list.size();
        while (pos > 0 && sorted_list[pos-1] > req.value) pos--;
        sorted_list.insert(pos, req.value);
        list_total = list_total + TOTAL_W'(req.value);
        res.status = ST_INSERTED;
      end
    end else begin
      if (TOTAL_W'(req.value) > list_total) begin
        res.status = ST_OVER_TOTAL;
      end else begin
        pos = 0;
        while (pos < sorted_list.size() && sorted_list[pos] < req.value) pos++;
        if (pos >= sorted_list.size() || sorted_list[pos] != req.value) begin
          res.status = ST_NOT_FOUND;
        end else begin
          sorted_list.delete(pos);
          list_total = list_total - TOTAL_W'(req.value);
          res.status = ST_REMOVED;
        end
      end
    end
    res.entry_count  = COUNT_W'(sorted_list.size());
    res.smallest     = (sorted_list.size() != 0) ? sorted_list[0] : '0;
    res.largest      = (sorted_list.size() != 0) ? sorted_list[$] : '0;
    res.stored_total = list_total;
    return res;
  endfunction

  function automatic void queue_item(logic action, logic [VAL_W-1:0] value,
                                     logic wait_drain);
    request_t req;
    req.action     = action;
    req.value      = value;
    req.wait_drain = wait_drain;
    pending_reqs.push_back(req);
    if (action == ACT_INSERT) begin
      if (gen_pool.size() < CAPACITY) begin
        gen_pool.push_back(value);
        gen_total += value;
      end
    end else if (value <= gen_total) begin
      foreach (gen_pool[i]) begin
        if (gen_pool[i] == value) begin
          gen_pool.delete(i);
          gen_total -= value;
          break;
        end
      end
    end
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = VAL_W'($urandom_range(0, 15));  // lots of duplicates
      4: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = 16'h0001;
          2: v = 16'hfffe;
          default: v = 16'hffff;
        endcase
      end
      default: v = VAL_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] pick_removal();
    logic [VAL_W-1:0] v;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7 && gen_pool.size() != 0)
      v = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
    else if (sel == 7 && gen_total < 65535)
      v = VAL_W'($urandom_range(gen_total + 1, 65535));  // above the total
    else
      v = pick_value();
    return v;
  endfunction

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk or negedge rst_ni) begin
    static request_t    drive_req;
    static int unsigned burst_left = 1;
    static int unsigned gap_left   = 0;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.action <= ACT_INSERT;
      in_if.value  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(list_apply(drive_req));
        items_acc <= items_acc + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].wait_drain &&
                      (in_if.valid || items_acc != results_got))) begin
          in_if.valid <= 1'b0;
        end else begin
          drive_req = pending_reqs.pop_front();
          in_if.valid  <= 1'b1;
          in_if.action <= drive_req.action;
          in_if.value  <= drive_req.value;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Monitor: scoreboard check plus receiver stall pattern
  always @(posedge clk or negedge rst_ni) begin
    static int unsigned rx_cycle     = 0;
    static int unsigned rx_mode      = 0;
    static int unsigned hold_left    = 0;
    static bit          holdoff_done = 1'b0;
    list_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_got <= results_got + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected: status %0d count %0d",
                     $time, out_if.status, out_if.entry_count);
        end else begin
          want = expected_results.pop_front();
          if (out_if.status !== want.status || out_if.entry_count !== want.entry_count ||
              out_if.smallest !== want.smallest || out_if.largest !== want.largest ||
              out_if.stored_total !== want.stored_total) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch exp %0d %0d %0d %0d %0d / got %0d %0d %0d %0d %0d",
                       $time,
                       want.status, want.entry_count, want.smallest, want.largest,
                       want.stored_total, out_if.status, out_if.entry_count,
                       out_if.smallest, out_if.largest, out_if.stored_total);
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      // one long hold-off so the block fills up and backs up its input
      if (!holdoff_done && results_got >= 150) begin
        holdoff_done = 1'b1;
        hold_left    = HOLDOFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (rx_cycle % 8 != 3) && (rx_cycle % 8 != 4);
        endcase
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL sorted_list_insert_remove");
        $finish;
      end
    end
  end

  initial begin
    int unsigned rand_count;
    int unsigned seg;
    int unsigned seg_len;
    bit          first;
    clk          = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_INSERT;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    items_acc    = 0;
    results_got  = 0;
    mismatches   = 0;
    idle_cycles  = 0;
    list_total   = '0;
    gen_total    = 0;

    // directed: empty-store removes, extremes, duplicates, over-total, not found
    queue_item(ACT_REMOVE, 16'd0,     1'b0);  // empty store -> not found
    queue_item(ACT_REMOVE, 16'd5,     1'b0);  // empty store, above total
    queue_item(ACT_INSERT, 16'hffff,  1'b0);
    queue_item(ACT_INSERT, 16'd0,     1'b0);
    queue_item(ACT_INSERT, 16'd0,     1'b0);
    queue_item(ACT_INSERT, 16'd7,     1'b0);
    queue_item(ACT_INSERT, 16'd7,     1'b0);
    queue_item(ACT_INSERT, 16'h8000,  1'b0);
    queue_item(ACT_REMOVE, 16'd8,     1'b0);  // not present
    queue_item(ACT_REMOVE, 16'hffff,  1'b0);
    queue_item(ACT_REMOVE, 16'h8000,  1'b0);
    queue_item(ACT_REMOVE, 16'd20,    1'b0);  // total is 14 now
    queue_item(ACT_REMOVE, 16'd7,     1'b0);
    queue_item(ACT_REMOVE, 16'd0,     1'b0);
    queue_item(ACT_REMOVE, 16'd0,     1'b0);
    queue_item(ACT_REMOVE, 16'd7,     1'b0);
    queue_item(ACT_REMOVE, 16'd0,     1'b0);  // empty again
    queue_item(ACT_INSERT, 16'h5555,  1'b0);
    queue_item(ACT_INSERT, 16'haaaa,  1'b0);
    queue_item(ACT_REMOVE, 16'h5555,  1'b0);
    queue_item(ACT_REMOVE, 16'haaaa,  1'b0);

    // random segments: fill to capacity first, then mixed workloads
    rand_count = 0;
    first      = 1'b1;
    while (rand_count < RANDOM_ITEMS) begin
      seg = first ? 0 : $urandom_range(0, 7);
      case (seg)
        0: begin
          while (gen_pool.size() < CAPACITY) begin
            queue_item(ACT_INSERT, pick_value(), first);
            first = 1'b0;
            rand_count++;
          end
          repeat (3) begin
            queue_item(ACT_INSERT, pick_value(), 1'b0);  // full
            rand_count++;
          end
        end
        1: begin
          // empty the store, then poke it while empty
          while (gen_pool.size() != 0) begin
            queue_item(ACT_REMOVE, gen_pool[$urandom_range(0, gen_pool.size() - 1)],
                       1'b0);
            rand_count++;
          end
          queue_item(ACT_REMOVE, 16'd0, 1'b0);
          queue_item(ACT_REMOVE, pick_value(), 1'b0);
          rand_count += 2;
        end
        default: begin
          seg_len = $urandom_range(10, 40);
          repeat (seg_len) begin
            // 2,3 lean to removes, 4,5 to inserts, the rest even
            if ($urandom_range(0, 9) < ((seg < 4) ? 2 : (seg < 6) ? 8 : 5))
              queue_item(ACT_INSERT, pick_value(), ($urandom_range(0, 39) == 0));
            else
              queue_item(ACT_REMOVE, pick_removal(), ($urandom_range(0, 39) == 0));
            rand_count++;
          end
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || items_acc != results_got) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;

    if (mismatches == 0)
      $display("PASS sorted_list_insert_remove");
    else
      $display("FAIL sorted_list_insert_remove");
    $finish;
  end

endmodule

// File: sorted_list_insert_remove.f
sv/sli_pkg.sv
sv/sli_in_if.sv
sv/sli_out_if.sv
sv/sli_cell.sv
sv/sorted_list_insert_remove.sv
sim/testbench.sv
